// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/fnla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnla_pkg
// types and constants of the single-precision natural log pipeline
// ----------------------------------------------------------------------------
package fnla_pkg;

  typedef logic [31:0] fp_t;
  // wide signed exponent for the fused multiply-add datapath
  typedef logic signed [11:0] xexp_t;

  localparam fp_t FP_ONE        = 32'h3f80_0000;
  localparam fp_t FP_MINUS_ONE  = 32'hbf80_0000;
  localparam fp_t FP_MINUS_ZERO = 32'h8000_0000;
  localparam fp_t FP_QNAN       = 32'h7fc0_0000;
  localparam fp_t FP_INF_MAG    = 32'h7f80_0000;
  localparam fp_t C_P5          = 32'h3e6c_6078;
  localparam fp_t C_P4          = 32'hbe8e_f46d;
  localparam fp_t C_P3          = 32'h3ea9_e51a;
  localparam fp_t C_P2          = 32'hbeff_712d;
  localparam fp_t C_LN2         = 32'h3f31_7218;
  localparam fp_t RANGE_OFFSET  = 32'h3f2a_aaab;
  localparam fp_t EXP_MASK      = 32'hff80_0000;

  // register stages in one fused multiply-add
  localparam int FMA_STAGES = 4;
  // fma levels in the dependency chain
  localparam int FMA_LEVELS = 5;
  // front stage plus the fma levels
  localparam int LATENCY    = 1 + FMA_STAGES * FMA_LEVELS;

endpackage

// ===== sv/fnla_fma.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnla_fma
// four-stage single-precision fused multiply-add, round to nearest even
// ----------------------------------------------------------------------------
module fnla_fma (
  input  logic          clk,
  input  logic          en,
  input  fnla_pkg::fp_t a,
  input  fnla_pkg::fp_t b,
  input  fnla_pkg::fp_t c,
  output fnla_pkg::fp_t r
);
  import fnla_pkg::*;

  function automatic logic [5:0] msb64(logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  // ---------------- stage 1: unpack, special operands, multiply
  logic        sa, sb, sc, ps;
  logic [7:0]  ea, eb, ec;
  logic [23:0] ma, mb, mc;
  xexp_t       xa, xb, xc;
  logic        spec;
  fp_t         spec_val;

  logic [47:0] s1_pm_r;
  xexp_t       s1_xab_r, s1_xc_r;
  logic [23:0] s1_mc_r;
  logic        s1_ps_r, s1_sc_r, s1_spec_r;
  fp_t         s1_spec_val_r;

  always_comb begin
    sa = a[31];
    sb = b[31];
    sc = c[31];
    ps = sa ^ sb;
    ea = a[30:23];
    eb = b[30:23];
    ec = c[30:23];
    ma = {ea != 8'd0, a[22:0]};
    mb = {eb != 8'd0, b[22:0]};
    mc = {ec != 8'd0, c[22:0]};
    xa = $signed({4'd0, (ea != 8'd0) ? ea : 8'd1}) - 12'sd150;
    xb = $signed({4'd0, (eb != 8'd0) ? eb : 8'd1}) - 12'sd150;
    xc = $signed({4'd0, (ec != 8'd0) ? ec : 8'd1}) - 12'sd150;
    spec     = 1'b1;
    spec_val = '0;
    if (ea == 8'hff && a[22:0] != 23'd0) begin
      spec_val = a | 32'h0040_0000;
    end else if (eb == 8'hff && b[22:0] != 23'd0) begin
      spec_val = b | 32'h0040_0000;
    end else if (ec == 8'hff && c[22:0] != 23'd0) begin
      spec_val = c | 32'h0040_0000;
    end else if ((ea == 8'hff && b[30:0] == 31'd0) || (eb == 8'hff && a[30:0] == 31'd0)) begin
      spec_val = FP_QNAN;
    end else if (ea == 8'hff || eb == 8'hff) begin
      spec_val = (ec == 8'hff && sc != ps) ? FP_QNAN : ({ps, 31'd0} | FP_INF_MAG);
    end else if (ec == 8'hff) begin
      spec_val = c;
    end else if (ma == 24'd0 || mb == 24'd0) begin
      // zero product
      spec_val = (mc == 24'd0) ? {ps & sc, 31'd0} : c;
    end else begin
      spec = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pm_r       <= ma * mb;
      s1_xab_r      <= xa + xb;
      s1_xc_r       <= xc;
      s1_mc_r       <= mc;
      s1_ps_r       <= ps;
      s1_sc_r       <= sc;
      s1_spec_r     <= spec;
      s1_spec_val_r <= spec_val;
    end
  end

  // ---------------- stage 2: normalise both terms to bit 61, order them
  logic [5:0]  p1, p2;
  logic [63:0] m1, m2;
  xexp_t       x1, x2, dd;
  logic [63:0] big_nxt, small_nxt;
  xexp_t       xbig_nxt;
  logic        sbig_nxt, ssmall_nxt;

  logic [63:0] s2_big_r, s2_small_r;
  xexp_t       s2_xbig_r;
  logic        s2_sbig_r, s2_sub_r, s2_far_r, s2_spec_r;
  logic [5:0]  s2_d_r;
  fp_t         s2_spec_val_r;

  always_comb begin
    p1 = msb64({16'd0, s1_pm_r});
    p2 = msb64({40'd0, s1_mc_r});
    m1 = {16'd0, s1_pm_r} << (6'd61 - p1);
    m2 = {40'd0, s1_mc_r} << (6'd61 - p2);
    x1 = s1_xab_r - $signed({6'd0, 6'd61 - p1});
    x2 = s1_xc_r - $signed({6'd0, 6'd61 - p2});
    if (s1_mc_r == 24'd0) begin
      big_nxt = m1; xbig_nxt = x1; sbig_nxt = s1_ps_r;
      small_nxt = '0; ssmall_nxt = s1_ps_r; dd = '0;
    end else if (x1 > x2 || (x1 == x2 && m1 >= m2)) begin
      big_nxt = m1; xbig_nxt = x1; sbig_nxt = s1_ps_r;
      small_nxt = m2; ssmall_nxt = s1_sc_r; dd = x1 - x2;
    end else begin
      big_nxt = m2; xbig_nxt = x2; sbig_nxt = s1_sc_r;
      small_nxt = m1; ssmall_nxt = s1_ps_r; dd = x2 - x1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_big_r      <= big_nxt;
      s2_small_r    <= small_nxt;
      s2_xbig_r     <= xbig_nxt;
      s2_sbig_r     <= sbig_nxt;
      s2_sub_r      <= sbig_nxt != ssmall_nxt;
      s2_far_r      <= dd >= 12'sd64;
      s2_d_r        <= dd[5:0];
      s2_spec_r     <= s1_spec_r;
      s2_spec_val_r <= s1_spec_val_r;
    end
  end

  // ---------------- stage 3: align the smaller term with sticky, add
  logic [127:0] aln;
  logic [63:0]  sm, sum;

  logic [63:0] s3_sum_r;
  xexp_t       s3_xbig_r;
  logic        s3_sbig_r, s3_zero_r, s3_spec_r;
  fp_t         s3_spec_val_r;

  always_comb begin
    aln = {s2_small_r, 64'd0} >> s2_d_r;
    sm  = s2_far_r ? 64'd1 : (aln[127:64] | {63'd0, |aln[63:0]});
    sum = s2_sub_r ? (s2_big_r - sm) : (s2_big_r + sm);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sum_r      <= sum;
      s3_xbig_r     <= s2_xbig_r;
      s3_sbig_r     <= s2_sbig_r;
      s3_zero_r     <= s2_sub_r && sum == 64'd0;
      s3_spec_r     <= s2_spec_r;
      s3_spec_val_r <= s2_spec_val_r;
    end
  end

  // ---------------- stage 4: round and pack
  logic [5:0]   p3;
  xexp_t        lsb, sh, expf, nsh;
  logic [127:0] rx;
  logic [63:0]  ql;
  logic [24:0]  q;
  logic [32:0]  bits;
  fp_t          res;
  fp_t          r_r;

  always_comb begin
    p3   = msb64(s3_sum_r);
    lsb  = $signed({6'd0, p3}) + s3_xbig_r - 12'sd23;
    if (lsb < -12'sd149) lsb = -12'sd149;
    sh   = lsb - s3_xbig_r;
    expf = lsb + 12'sd150;
    nsh  = -sh;
    rx   = {s3_sum_r, 64'd0} >> sh[5:0];
    ql   = s3_sum_r << nsh[4:0];
    if (sh <= 12'sd0) begin
      q = ql[24:0];
    end else if (sh >= 12'sd64) begin
      q = '0;
    end else begin
      q = rx[88:64] + {24'd0, rx[63] && ((|rx[62:0]) || rx[64])};
    end
    bits = {2'd0, 8'(expf - 12'sd1), 23'd0} + {8'd0, q};
    if (expf >= 12'sd255 || bits >= {1'b0, FP_INF_MAG}) begin
      res = {s3_sbig_r, 31'd0} | FP_INF_MAG;
    end else begin
      res = {s3_sbig_r, bits[30:0]};
    end
    if (s3_spec_r) begin
      res = s3_spec_val_r;
    end else if (s3_zero_r) begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= res;
    end
  end

  assign r = r_r;

endmodule

// ===== sv/float_natural_log_approx.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_natural_log_approx
// approximate natural log of a single-precision value, fully pipelined
//
//   channel | ports                         | direction
//   --------+-------------------------------+----------
//   in      | in_valid in_ready in_operand_bits | into block
//   out     | out_valid out_ready out_log_bits  | out of block
//
// one beat accepted per cycle while the output is not stalled; each operand
// passes the front stage, then five chained fused multiply-adds of four stages each
// throughput is set by the pipeline: one new operand every clock while the output is not stalled
// reset clears the valid bits only; datapath registers are not reset
// a stalled output freezes the whole pipeline, nothing is dropped
// ----------------------------------------------------------------------------
module float_natural_log_approx (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  fnla_pkg::fp_t in_operand_bits,
  output logic          out_valid,
  input  logic          out_ready,
  output fnla_pkg::fp_t out_log_bits
);
  import fnla_pkg::*;

  localparam int F_DLY  = 2 * FMA_STAGES;
  localparam int S_DLY  = FMA_STAGES;
  localparam int IB_DLY = (FMA_LEVELS - 1) * FMA_STAGES;

  logic en;
  logic vld_r [LATENCY];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // front stage: range reduction and exponent to float
  fp_t        e_w, m_w, ib_w;
  logic [8:0] k, ak;
  logic [3:0] kp;
  logic [31:0] kfrac;
  fp_t        m_r, ib_r;

  always_comb begin
    e_w  = (in_operand_bits - RANGE_OFFSET) & EXP_MASK;
    m_w  = in_operand_bits - e_w;
    k    = e_w[31:23];
    ak   = k[8] ? (9'd0 - k) : k;
    kp   = '0;
    for (int i = 0; i < 9; i++) begin
      if (ak[i]) kp = 4'(i);
    end
    kfrac = {23'd0, ak} << (5'd23 - {1'b0, kp});
    ib_w  = (k == 9'd0) ? '0 : {k[8], 8'd127 + {4'd0, kp}, kfrac[22:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r  <= m_w;
      ib_r <= ib_w;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LATENCY; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LATENCY; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  fp_t f_w, s_w, r1_w, t_w, r2_w, r3_w, res_w;
  fp_t f_d_r  [F_DLY];
  fp_t s_d_r  [S_DLY];
  fp_t ib_d_r [IB_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      f_d_r[0]  <= f_w;
      s_d_r[0]  <= s_w;
      ib_d_r[0] <= ib_r;
      for (int i = 1; i < F_DLY; i++)  f_d_r[i]  <= f_d_r[i-1];
      for (int i = 1; i < S_DLY; i++)  s_d_r[i]  <= s_d_r[i-1];
      for (int i = 1; i < IB_DLY; i++) ib_d_r[i] <= ib_d_r[i-1];
    end
  end

  fnla_fma u_f  (.clk, .en, .a(m_r),  .b(FP_ONE), .c(FP_MINUS_ONE),  .r(f_w));
  fnla_fma u_s  (.clk, .en, .a(f_w),  .b(f_w),    .c(FP_MINUS_ZERO), .r(s_w));
  fnla_fma u_r1 (.clk, .en, .a(C_P5), .b(f_w),    .c(C_P4),          .r(r1_w));
  fnla_fma u_t  (.clk, .en, .a(C_P3), .b(f_w),    .c(C_P2),          .r(t_w));
  fnla_fma u_r2 (.clk, .en, .a(r1_w), .b(s_w),    .c(t_w),           .r(r2_w));
  fnla_fma u_r3 (.clk, .en, .a(r2_w), .b(s_d_r[S_DLY-1]), .c(f_d_r[F_DLY-1]), .r(r3_w));
  fnla_fma u_ln (.clk, .en, .a(ib_d_r[IB_DLY-1]), .b(C_LN2), .c(r3_w), .r(res_w));

  assign out_valid    = vld_r[LATENCY-1];
  assign out_log_bits = res_w;

endmodule

// ===== sv/fnla_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnla_chk
// port-level checks on the natural log pipeline
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fnla_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input fnla_pkg::fp_t out_log_bits
);
  import fnla_pkg::*;

  // a held result beat keeps its value
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_log_bits), "result changed while stalled")
  // input side stalls only while a result is stuck
  `ASSERT_CLK(a_ready_link, in_ready == (!out_valid || out_ready), "input ready not tied to output stall")
  // reset empties the pipeline
  `ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result valid right after reset")
  // a stall keeps the output beat present and the input closed
  `ASSERT_CLK(a_stall_closed, out_valid && !out_ready |-> !in_ready, "input open during stall")

endmodule

bind float_natural_log_approx fnla_chk u_fnla_chk (.*);
